[sv/ssi_pkg.sv]
// ----------------------------------------------------------------------------
// ssi_pkg - shared constants and types for the segment intersection block
// Widths of the difference, product and quotient paths, and status codes.
// ----------------------------------------------------------------------------
package ssi_pkg;

  localparam int CW  = 32;        // Q16.16 coordinate width
  localparam int TW  = 16;        // tolerance register width
  localparam int DW  = CW + 1;    // coordinate difference width, signed
  localparam int PW  = 2 * DW;    // product of two differences, signed
  localparam int SW  = PW + 1;    // sum of two products, signed
  localparam int MW  = SW - 1;    // magnitude of such a sum
  localparam int QW  = 34;        // quotient bits produced by the divider
  localparam int NW  = MW + QW;   // divider numerator width
  localparam int FRAC = 16;       // fraction bits of Q16.16
  localparam int DIV_LAT = QW + 2;

  localparam logic signed [DW:0] ONE_Q16 = (DW + 1)'(65536);

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_DEGEN    = 2'd1,
    ST_PARALLEL = 2'd2,
    ST_OUTSIDE  = 2'd3
  } status_t;

endpackage

[sv/segment_segment_intersection.sv]
// ----------------------------------------------------------------------------
// segment_segment_intersection - 2D segment pair intersection, Q16.16
// Rejects degenerate and parallel pairs, returns both line parameters and the
// crossing point, with an optional interior test against the tolerance.
// ----------------------------------------------------------------------------
//
//  channel   signals                                     dir  transaction
//  item      item_valid/item_ready, ax..dy, segment_only in   one segment pair
//  result    result_valid/result_ready, status..int_y    out  one answer
//  cfg       cfg_valid/cfg_ready, cfg_data               in   tolerance write
//
//  One transaction enters per cycle while the result is not stalled; each item
//  passes through 6 arithmetic stages, 36 divider stages and 1 output stage.
//  Most of the depth is in the four bit-per-stage dividers, which run side by side.
//  rst is synchronous and clears the valid bits and sets tolerance to 1.
//  A stalled result freezes the whole pipeline; nothing is dropped or repeated.
//
module segment_segment_intersection (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ssi_pkg::TW-1:0]     cfg_data,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  logic signed [ssi_pkg::CW-1:0] ax,
  input  logic signed [ssi_pkg::CW-1:0] ay,
  input  logic signed [ssi_pkg::CW-1:0] bx,
  input  logic signed [ssi_pkg::CW-1:0] by_coord,
  input  logic signed [ssi_pkg::CW-1:0] cx,
  input  logic signed [ssi_pkg::CW-1:0] cy,
  input  logic signed [ssi_pkg::CW-1:0] dx,
  input  logic signed [ssi_pkg::CW-1:0] dy,
  input  logic                       segment_only,
  output logic                       result_valid,
  input  logic                       result_ready,
  output logic [1:0]                 status,
  output logic signed [ssi_pkg::CW-1:0] t_ab,
  output logic signed [ssi_pkg::CW-1:0] t_cd,
  output logic signed [ssi_pkg::CW-1:0] int_x,
  output logic signed [ssi_pkg::CW-1:0] int_y
);
  import ssi_pkg::*;

  localparam int NV = 6 + DIV_LAT + 1;

  typedef struct packed {
    status_t              st;
    logic                 seg;
    logic                 neg_t;
    logic                 neg_s;
    logic                 neg_x;
    logic                 neg_y;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
  } side_t;

  function automatic logic signed [CW-1:0] sat32(input logic signed [QW+1:0] v);
    logic signed [QW+1:0] vmax;
    logic signed [QW+1:0] vmin;
    vmax = (QW + 2)'(2147483647);
    vmin = -vmax - (QW + 2)'(1);
    if (v > vmax)      sat32 = vmax[CW-1:0];
    else if (v < vmin) sat32 = vmin[CW-1:0];
    else               sat32 = v[CW-1:0];
  endfunction

  // squared length below tolerance, only possible for short vectors
  function automatic logic short_vec(input logic signed [DW-1:0] x,
                                     input logic signed [DW-1:0] y,
                                     input logic [TW-1:0] tol);
    logic sx, sy;
    logic [DW-1:0] xa, ya;
    logic [FRAC-1:0] xm, ym;
    logic [2*FRAC:0] ss;
    sx = (x >= -DW'(65535)) && (x <= DW'(65535));
    sy = (y >= -DW'(65535)) && (y <= DW'(65535));
    xa = x[DW-1] ? DW'(-x) : DW'(x);
    ya = y[DW-1] ? DW'(-y) : DW'(y);
    xm = xa[FRAC-1:0];
    ym = ya[FRAC-1:0];
    ss = (2*FRAC + 1)'(xm * xm) + (2*FRAC + 1)'(ym * ym);
    short_vec = sx && sy && (ss < {1'b0, tol, {FRAC{1'b0}}});
  endfunction

  logic [TW-1:0] tolerance;
  logic [NV-1:0] vld;
  logic          en;

  // stage 1: differences
  logic signed [DW-1:0] ux1, uy1, vx1, vy1, acx1, acy1;
  logic signed [CW-1:0] ax1, ay1;
  logic                 seg1;
  // stage 2: cross products
  logic signed [PW-1:0] pd1, pd2, pt1, pt2, ps1, ps2;
  logic signed [DW-1:0] ux2, uy2;
  logic signed [CW-1:0] ax2, ay2;
  logic                 seg2, deg2;
  // stage 3: numerators and denominator
  logic signed [SW-1:0] den3, tn3, sn3;
  logic signed [DW-1:0] ux3, uy3;
  logic signed [CW-1:0] ax3, ay3;
  logic                 seg3, deg3;
  // stage 4: magnitudes and signs
  logic [MW-1:0]        dm4, tm4, sm4;
  logic [DW-1:0]        uxm4, uym4;
  side_t                sd4;
  // stage 5: partial products of tn by u
  logic [2*DW-1:0]      pxl5, pxh5, pyl5, pyh5;
  logic [MW-1:0]        dm5, tm5, sm5;
  side_t                sd5;
  // stage 6: divider operands
  logic [NW-1:0]        nt6, ns6, nx6, ny6;
  logic [MW-1:0]        dm6;
  side_t                sd6;
  side_t                sdd [DIV_LAT];
  logic [QW:0]          qt, qs, qx, qy;

  assign cfg_ready    = 1'b1;
  assign en           = !vld[NV-1] || result_ready;
  assign item_ready   = en;
  assign result_valid = vld[NV-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TW'(1);
    end else if (cfg_valid && cfg_ready) begin
      tolerance <= cfg_data;
    end
  end

  // valid bits advance with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NV-2:0], item_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ux1  <= DW'(bx) - DW'(ax);
      uy1  <= DW'(by_coord) - DW'(ay);
      vx1  <= DW'(dx) - DW'(cx);
      vy1  <= DW'(dy) - DW'(cy);
      acx1 <= DW'(ax) - DW'(cx);
      acy1 <= DW'(ay) - DW'(cy);
      ax1  <= ax;
      ay1  <= ay;
      seg1 <= segment_only;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pd1  <= uy1 * vx1;
      pd2  <= ux1 * vy1;
      pt1  <= vx1 * acy1;
      pt2  <= vy1 * acx1;
      ps1  <= acx1 * uy1;
      ps2  <= acy1 * ux1;
      deg2 <= short_vec(ux1, uy1, tolerance) || short_vec(vx1, vy1, tolerance);
      ux2  <= ux1;
      uy2  <= uy1;
      ax2  <= ax1;
      ay2  <= ay1;
      seg2 <= seg1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den3 <= SW'(pd1) - SW'(pd2);
      tn3  <= SW'(pt2) - SW'(pt1);
      sn3  <= SW'(ps1) - SW'(ps2);
      ux3  <= ux2;
      uy3  <= uy2;
      ax3  <= ax2;
      ay3  <= ay2;
      seg3 <= seg2;
      deg3 <= deg2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dm4  <= den3[SW-1] ? MW'(-den3) : MW'(den3);
      tm4  <= tn3[SW-1]  ? MW'(-tn3)  : MW'(tn3);
      sm4  <= sn3[SW-1]  ? MW'(-sn3)  : MW'(sn3);
      uxm4 <= ux3[DW-1]  ? DW'(-ux3)  : DW'(ux3);
      uym4 <= uy3[DW-1]  ? DW'(-uy3)  : DW'(uy3);
      sd4.st    <= deg3 ? ST_DEGEN : ((den3 == '0) ? ST_PARALLEL : ST_HIT);
      sd4.seg   <= seg3;
      sd4.neg_t <= tn3[SW-1] ^ den3[SW-1];
      sd4.neg_s <= sn3[SW-1] ^ den3[SW-1];
      sd4.neg_x <= tn3[SW-1] ^ den3[SW-1] ^ ux3[DW-1];
      sd4.neg_y <= tn3[SW-1] ^ den3[SW-1] ^ uy3[DW-1];
      sd4.ax    <= ax3;
      sd4.ay    <= ay3;
    end
  end

  // split |tn| into two halves so each multiply stays near 33 x 33
  always_ff @(posedge clk) begin
    if (en) begin
      pxl5 <= tm4[DW-1:0] * uxm4;
      pxh5 <= tm4[MW-1:DW] * uxm4;
      pyl5 <= tm4[DW-1:0] * uym4;
      pyh5 <= tm4[MW-1:DW] * uym4;
      dm5  <= dm4;
      tm5  <= tm4;
      sm5  <= sm4;
      sd5  <= sd4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nt6 <= NW'({tm5, {FRAC{1'b0}}});
      ns6 <= NW'({sm5, {FRAC{1'b0}}});
      nx6 <= NW'(pxl5) + NW'({pxh5, {DW{1'b0}}});
      ny6 <= NW'(pyl5) + NW'({pyh5, {DW{1'b0}}});
      dm6 <= dm5;
      sd6 <= sd5;
    end
  end

  ssi_div u_div_t (.clk(clk), .en(en), .num(nt6), .den(dm6), .quo(qt));
  ssi_div u_div_s (.clk(clk), .en(en), .num(ns6), .den(dm6), .quo(qs));
  ssi_div u_div_x (.clk(clk), .en(en), .num(nx6), .den(dm6), .quo(qx));
  ssi_div u_div_y (.clk(clk), .en(en), .num(ny6), .den(dm6), .quo(qy));

  // hold the side data alongside the dividers
  always_ff @(posedge clk) begin
    if (en) begin
      sdd[0] <= sd6;
      for (int i = 1; i < DIV_LAT; i++) begin
        sdd[i] <= sdd[i-1];
      end
    end
  end

  // output stage: apply signs, saturate, run the interior test
  side_t                sdf;
  logic signed [QW+1:0] vt, vs, vx, vy;
  logic signed [CW-1:0] tq, sq, px, py;
  logic signed [DW:0]   lo, hi;
  logic                 in_window;
  status_t              st_next;

  always_comb begin
    sdf = sdd[DIV_LAT-1];
    vt = sdf.neg_t ? -$signed({1'b0, qt}) : $signed({1'b0, qt});
    vs = sdf.neg_s ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
    vx = sdf.neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
    vy = sdf.neg_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
    tq = sat32(vt);
    sq = sat32(vs);
    px = sat32((QW + 2)'(sdf.ax) + vx);
    py = sat32((QW + 2)'(sdf.ay) + vy);
    lo = $signed({2'b00, tolerance});
    hi = ONE_Q16 - lo;
    in_window = ((DW + 1)'(tq) >= lo) && ((DW + 1)'(tq) <= hi)
             && ((DW + 1)'(sq) >= lo) && ((DW + 1)'(sq) <= hi);
    st_next = sdf.st;
    if (sdf.st == ST_HIT && sdf.seg && !in_window) st_next = ST_OUTSIDE;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      status <= st_next;
      t_ab   <= (st_next == ST_HIT) ? tq : '0;
      t_cd   <= (st_next == ST_HIT) ? sq : '0;
      int_x  <= (st_next == ST_HIT) ? px : '0;
      int_y  <= (st_next == ST_HIT) ? py : '0;
    end
  end

  // rejected pairs carry no numbers
  a_reject_zero : assert property (@(posedge clk) disable iff (rst)
    result_valid && status != ST_HIT |->
      t_ab == '0 && t_cd == '0 && int_x == '0 && int_y == '0)
    else $error("rejected result carries non-zero fields");

  // input back-pressure only comes from a stalled result
  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> result_valid && !result_ready)
    else $error("input stalled without a stalled result");

  // a frozen pipeline neither gains nor loses items
  a_stall_keep : assert property (@(posedge clk) disable iff (rst)
    !en |=> $countones(vld) == $past($countones(vld)))
    else $error("pipeline occupancy changed during a stall");

endmodule

[sv/ssi_div.sv]
// ----------------------------------------------------------------------------
// ssi_div - pipelined restoring divider with round-half-up and overflow cap
// One quotient bit per stage; quotients of 2^QW or more come out as 2^QW.
// ----------------------------------------------------------------------------
module ssi_div (
  input  logic                    clk,
  input  logic                    en,
  input  logic [ssi_pkg::NW-1:0]  num,
  input  logic [ssi_pkg::MW-1:0]  den,
  output logic [ssi_pkg::QW:0]    quo
);
  import ssi_pkg::*;

  logic [MW-1:0] rem [QW+1];
  logic [QW-1:0] low [QW+1];
  logic [QW-1:0] qb  [QW+1];
  logic [MW-1:0] dd  [QW+1];
  logic          ovf [QW+1];
  logic          up;

  // split the numerator: the high part must stay below the divisor
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num[NW-1:QW];
      low[0] <= num[QW-1:0];
      qb[0]  <= '0;
      dd[0]  <= den;
      ovf[0] <= (num[NW-1:QW] >= den);
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [MW:0] trial;
    logic        take;
    assign trial = {rem[k-1], low[k-1][QW-1]};
    assign take  = (trial >= {1'b0, dd[k-1]});
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= take ? MW'(trial - {1'b0, dd[k-1]}) : trial[MW-1:0];
        low[k] <= {low[k-1][QW-2:0], 1'b0};
        qb[k]  <= {qb[k-1][QW-2:0], take};
        dd[k]  <= dd[k-1];
        ovf[k] <= ovf[k-1];
      end
    end
  end

  // round up when twice the remainder reaches the divisor
  assign up = ({rem[QW], 1'b0} >= {1'b0, dd[QW]});

  always_ff @(posedge clk) begin
    if (en) begin
      quo <= ovf[QW] ? {1'b1, {QW{1'b0}}} : ({1'b0, qb[QW]} + (QW + 1)'(up));
    end
  end

endmodule
